// ----- rtl/itad_pkg.sv -----
// itad_pkg: shared types, character constants and digit encoding for the
// integer_to_ascii_digits block. No dependencies.

package itad_pkg;

    localparam int VALUE_WIDTH_DEF = 64;

    // ascii codes
    localparam logic [6:0] CH_ZERO    = 7'd48;
    localparam logic [6:0] CH_LOWER_A = 7'd97;
    localparam logic [6:0] CH_MINUS   = 7'd45;

    localparam logic [5:0] DIGIT_NINE = 6'd9;
    localparam logic [5:0] DIGIT_TEN  = 6'd10;
    localparam logic [5:0] RADIX_MIN  = 6'd2;
    localparam logic [5:0] RADIX_MAX  = 6'd36;

    localparam int BITS_PER_STEP = 8;

    typedef struct packed {
        logic [63:0] value;
        logic [5:0]  radix;
        logic        signed_mode;
    } in_t;

    typedef struct packed {
        logic [6:0] char_code;
        logic       last_char;
    } out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_RD,
        ST_EMIT
    } state_t;

    function automatic logic [6:0] digit_to_ascii(input logic [5:0] d);
        logic [6:0] code;
        if (d <= DIGIT_NINE)
        begin
            code = CH_ZERO + 7'(d);
        end
        else
        begin
            code = CH_LOWER_A + 7'(d - DIGIT_TEN);
        end
        return code;
    endfunction

endpackage

// ----- rtl/itad_front.sv -----
// itad_front: classifies one incoming transaction into magnitude, clamped
// radix and sign flag. Depends on itad_pkg.

module itad_front #(
    parameter int VALUE_WIDTH = itad_pkg::VALUE_WIDTH_DEF,
    parameter int DIV_W       = 64
) (
    input  itad_pkg::in_t     item,
    output logic [DIV_W-1:0]  mag,
    output logic [5:0]        radix,
    output logic              neg
);
    import itad_pkg::*;

    logic [31:0] low;
    logic [31:0] low_abs;

    assign low     = item.value[31:0];
    assign low_abs = low[31] ? (32'd0 - low) : low;

    always_comb
    begin
        if (item.radix < RADIX_MIN)
        begin
            radix = RADIX_MIN;
        end
        else if (item.radix > RADIX_MAX)
        begin
            radix = RADIX_MAX;
        end
        else
        begin
            radix = item.radix;
        end
    end

    always_comb
    begin
        if (item.signed_mode)
        begin
            // -2147483648 wraps to itself, read as unsigned it is the right magnitude
            neg = low[31];
            mag = DIV_W'(low_abs);
        end
        else
        begin
            neg = 1'b0;
            mag = DIV_W'(item.value[VALUE_WIDTH-1:0]);
        end
    end

endmodule

// ----- rtl/itad_fifo.sv -----
// itad_fifo: two-entry queue between the front and back parts.
// No dependencies.

module itad_fifo #(
    parameter int WIDTH = 71
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             valid
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == 2'd2);
    assign valid   = (count_reg != 2'd0);
    assign rd_data = slot_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && valid;

    always_comb
    begin
        wr_ptr_next = do_wr ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- rtl/itad_back.sv -----
// itad_back: digit extraction by repeated division by the radix, eight
// dividend bits per cycle, a digit stack, and the result register.
// Depends on itad_pkg.

module itad_back #(
    parameter int DIV_W = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    input  logic [DIV_W-1:0]  job_mag,
    input  logic [5:0]        job_radix,
    input  logic              job_neg,
    output logic              job_pop,
    output itad_pkg::out_t    result,
    output logic              result_valid,
    input  logic              pop
);
    import itad_pkg::*;

    localparam int CHUNKS = DIV_W / BITS_PER_STEP;
    localparam int CW     = $clog2(CHUNKS);
    localparam int AW     = $clog2(DIV_W);
    localparam int NW     = $clog2(DIV_W + 1);

    state_t                  state_reg;
    state_t                  state_next;
    logic [DIV_W-1:0]        div_reg;
    logic [DIV_W-1:0]        div_next;
    logic [5:0]              rem_reg;
    logic [5:0]              rem_next;
    logic [5:0]              radix_reg;
    logic [5:0]              radix_next;
    logic                    neg_reg;
    logic                    neg_next;
    logic [CW-1:0]           chunk_reg;
    logic [CW-1:0]           chunk_next;
    logic [NW-1:0]           nd_reg;
    logic [NW-1:0]           nd_next;
    logic [NW-1:0]           nd_dec;
    out_t                    out_reg;
    out_t                    out_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;

    logic [5:0]              stack_mem [DIV_W];
    logic [5:0]              rd_data_reg;
    logic                    wr_en;
    logic                    rd_en;

    logic [DIV_W-1:0]        div_step;
    logic [5:0]              rem_step;
    logic [BITS_PER_STEP-1:0] q_bits;
    logic                    last_chunk;
    logic                    quot_zero;
    logic                    slot_free;
    logic                    out_load;
    out_t                    out_new;

    assign last_chunk   = (chunk_reg == CW'(CHUNKS - 1));
    assign quot_zero    = (div_step == '0);
    assign slot_free    = !out_valid_reg || pop;
    assign nd_dec       = nd_reg - NW'(1);
    assign result       = out_reg;
    assign result_valid = out_valid_reg;

    // eight restoring steps, remainder stays below the radix
    always_comb
    begin
        logic [5:0] r;
        logic [6:0] trial;
        r = rem_reg;
        for (int k = 0; k < BITS_PER_STEP; k++)
        begin
            trial = {r, div_reg[DIV_W-1-k]};
            if (trial >= {1'b0, radix_reg})
            begin
                trial = trial - {1'b0, radix_reg};
                q_bits[BITS_PER_STEP-1-k] = 1'b1;
            end
            else
            begin
                q_bits[BITS_PER_STEP-1-k] = 1'b0;
            end
            r = trial[5:0];
        end
        rem_step = r;
        div_step = {div_reg[DIV_W-BITS_PER_STEP-1:0], q_bits};
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (last_chunk && quot_zero)
                begin
                    state_next = neg_reg ? ST_SIGN : ST_RD;
                end
            end
            ST_SIGN:
            begin
                if (slot_free)
                begin
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = (nd_reg == NW'(1)) ? ST_IDLE : ST_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        job_pop    = 1'b0;
        div_next   = div_reg;
        rem_next   = rem_reg;
        radix_next = radix_reg;
        neg_next   = neg_reg;
        chunk_next = chunk_reg;
        nd_next    = nd_reg;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        out_load   = 1'b0;
        out_new    = '{char_code: CH_MINUS, last_char: 1'b0};
        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop    = 1'b1;
                    div_next   = job_mag;
                    radix_next = job_radix;
                    neg_next   = job_neg;
                    rem_next   = '0;
                    chunk_next = '0;
                    nd_next    = '0;
                end
            end
            ST_DIV:
            begin
                div_next = div_step;
                if (last_chunk)
                begin
                    wr_en      = 1'b1;
                    nd_next    = nd_reg + NW'(1);
                    rem_next   = '0;
                    chunk_next = '0;
                end
                else
                begin
                    rem_next   = rem_step;
                    chunk_next = chunk_reg + CW'(1);
                end
            end
            ST_SIGN:
            begin
                out_load = slot_free;
            end
            ST_RD:
            begin
                rd_en = 1'b1;
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_load = 1'b1;
                    out_new  = '{char_code: digit_to_ascii(rd_data_reg),
                                 last_char: (nd_reg == NW'(1))};
                    nd_next  = nd_dec;
                end
            end
            default:
            begin
                job_pop = 1'b0;
            end
        endcase

        out_valid_next = out_valid_reg && !pop;
        out_next       = out_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_next       = out_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            chunk_reg     <= '0;
            nd_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chunk_reg     <= chunk_next;
            nd_reg        <= nd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg   <= div_next;
        rem_reg   <= rem_next;
        radix_reg <= radix_next;
        neg_reg   <= neg_next;
        out_reg   <= out_next;
    end

    // digit stack, least significant digit at the bottom
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stack_mem[nd_reg[AW-1:0]] <= rem_step;
        end
        if (rd_en)
        begin
            rd_data_reg <= stack_mem[nd_dec[AW-1:0]];
        end
    end

endmodule

// ----- rtl/integer_to_ascii_digits.sv -----
// integer_to_ascii_digits: one number in, its ascii digits out, msd first.
// Per item: an accept step, division by the radix for each digit (DIV_W = VALUE_WIDTH
// rounded up to a multiple of 8, at least 32), then the sign if any, then each character.
// The back end works on one item at a time.
// A two-entry queue takes new transactions while the back end is busy.
// Reset (rst_n, async low) empties the queue and the result register.

module integer_to_ascii_digits #(
    parameter int VALUE_WIDTH = itad_pkg::VALUE_WIDTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  itad_pkg::in_t  item,
    output logic           empty,
    input  logic           pop,
    output itad_pkg::out_t result
);
    import itad_pkg::*;

    localparam int BASE_W = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;
    localparam int DIV_W  = ((BASE_W + BITS_PER_STEP - 1) / BITS_PER_STEP) * BITS_PER_STEP;
    localparam int JOB_W  = DIV_W + 6 + 1;

    logic [DIV_W-1:0] f_mag;
    logic [5:0]       f_radix;
    logic             f_neg;
    logic [JOB_W-1:0] q_wr_data;
    logic [JOB_W-1:0] q_rd_data;
    logic             q_valid;
    logic             q_pop;
    logic             res_valid;

    itad_front #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .DIV_W       (DIV_W)
    ) u_front (
        .item  (item),
        .mag   (f_mag),
        .radix (f_radix),
        .neg   (f_neg)
    );

    assign q_wr_data = {f_neg, f_radix, f_mag};

    itad_fifo #(
        .WIDTH (JOB_W)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (q_wr_data),
        .full    (full),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .valid   (q_valid)
    );

    itad_back #(
        .DIV_W (DIV_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (q_valid),
        .job_mag      (q_rd_data[DIV_W-1:0]),
        .job_radix    (q_rd_data[DIV_W+5:DIV_W]),
        .job_neg      (q_rd_data[JOB_W-1]),
        .job_pop      (q_pop),
        .result       (result),
        .result_valid (res_valid),
        .pop          (pop)
    );

    assign empty = !res_valid;

endmodule

// ----- rtl/itad_checker.sv -----
// itad_checker: port-level assertions for integer_to_ascii_digits, bound
// to the top level. Depends on itad_pkg.

module itad_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           push,
    input logic           full,
    input itad_pkg::in_t  item,
    input logic           empty,
    input logic           pop,
    input itad_pkg::out_t result
);
    import itad_pkg::*;

    logic is_digit;
    logic is_letter;

    assign is_digit  = (result.char_code >= CH_ZERO) && (result.char_code <= 7'd57);
    assign is_letter = (result.char_code >= CH_LOWER_A) && (result.char_code <= 7'd122);

    // a waiting result holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("result changed while stalled");

    a_charset: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (is_digit || is_letter || result.char_code == CH_MINUS))
        else $error("illegal character code");

    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.char_code == CH_MINUS) |-> !result.last_char)
        else $error("sign marked as last character");

    // once a sign is taken, the next result is not another sign
    a_sign_then_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && result.char_code == CH_MINUS)
            |=> (empty || result.char_code != CH_MINUS))
        else $error("two signs in a row");

endmodule

bind integer_to_ascii_digits itad_checker u_itad_checker (.*);
